// File: src/ftlb_pkg.sv
// Shared types and constants for the process-tagged FIFO translation buffer.
// Used by ftlb_cell and fifo_tlb_with_process_tags_top; depends on nothing.
`timescale 1ns / 1ps

package ftlb_pkg;

    // Field widths fixed by the request and result formats
    localparam int TYPE_W  = 3;
    localparam int PID_W   = 16;
    localparam int PAGE_W  = 52;
    localparam int FRAME_W = 20;
    localparam int CNTR_W  = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request kinds
    localparam logic [TYPE_W-1:0] REQ_LOOKUP     = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_INSERT     = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_INVALIDATE = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_FLUSH_PROC = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_FLUSH_ALL  = 3'd4;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [PID_W-1:0]   process_id;
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame_number;
    } ftlb_req_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic [CNTR_W-1:0]  hit_count;
        logic [CNTR_W-1:0]  miss_count;
    } ftlb_rsp_t;

    // One translation held by a cell
    typedef struct packed {
        logic [PID_W-1:0]   process_id;
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame_number;
    } ftlb_entry_t;

    // Signals rippling from the oldest cell toward the newest
    typedef struct packed {
        logic               found;
        logic               hole;
        logic [FRAME_W-1:0] frame;
    } ftlb_chain_t;

    // Command broadcast to every cell
    typedef enum logic [2:0] {
        OP_NONE,
        OP_UPDATE,
        OP_APPEND,
        OP_EVICT_APPEND,
        OP_MARK_TAG,
        OP_MARK_PROC,
        OP_SQUEEZE
    } ftlb_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SQUEEZE
    } ftlb_state_t;

endpackage

// File: src/fifo_tlb_with_process_tags_top.sv
// Top level of the process-tagged FIFO translation buffer: request control,
// counters, capacity register and the row of ftlb_cell slots. Uses ftlb_pkg.
`timescale 1ns / 1ps
//
//  channel   ports                         handshake
//  -------   ---------------------------   -------------------------------
//  request   req (ftlb_req_t)              beat when start & !busy
//  result    rsp (ftlb_rsp_t)              beat on the cycle done is high
//  config    cfg_wdata (tlb_capacity)      written on cfg_we
//
//  Lookup, insert, flush-all and unknown codes pass from the idle state through
//  the execute state to the result beat; the tag compare ripples combinationally through the cell row.
//  Invalidate and flush-process mark the matches in the execute state; then, in
//  the squeeze state, the row closes one gap per cycle until none remain.
//  busy drops in the cycle that carries the result beat.
//  Reset (rst_n low) empties the table, clears the counters and sets the
//  capacity to 16. The receiver cannot stall: done lasts one cycle.

module fifo_tlb_with_process_tags_top
    import ftlb_pkg::*;
#(
    parameter int TLB_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ftlb_req_t        req,
    output logic             done,
    output ftlb_rsp_t        rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(TLB_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    ftlb_state_t      state_reg, state_next;
    ftlb_req_t        req_reg, req_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNTR_W-1:0] hits_reg, hits_next;
    logic [CNTR_W-1:0] misses_reg, misses_next;
    logic [CAP_W-1:0] cap_reg;
    ftlb_rsp_t        rsp_reg, rsp_next;
    logic             done_reg, done_next;
    ftlb_op_t         op;

    ftlb_chain_t      chain [TLB_DEPTH:0];
    ftlb_entry_t      ent   [TLB_DEPTH-1:0];
    logic             drop  [TLB_DEPTH-1:0];
    ftlb_entry_t      top_ent;

    logic [CMP_W-1:0] cap_ext, cap_eff, count_ext;
    logic             full;

    // Clamp capacity into 1..TLB_DEPTH
    assign cap_ext   = CMP_W'(cap_reg);
    assign count_ext = CMP_W'(count_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(TLB_DEPTH))
        begin
            cap_eff = CMP_W'(TLB_DEPTH);
        end
        else
        begin
            cap_eff = cap_ext;
        end
    end
    assign full = count_ext >= cap_eff;

    // Build the cell row, oldest at index 0
    assign chain[0] = '0;
    assign top_ent  = '0;

    for (genvar i = 0; i < TLB_DEPTH; i++)
    begin : g_cell
        ftlb_entry_t above_ent;
        logic        above_drop;

        if (i == TLB_DEPTH - 1)
        begin : g_last
            assign above_ent  = top_ent;
            assign above_drop = 1'b0;
        end
        else
        begin : g_mid
            assign above_ent  = ent[i+1];
            assign above_drop = drop[i+1];
        end

        ftlb_cell #(
            .TLB_DEPTH (TLB_DEPTH),
            .IDX       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .count      (count_reg),
            .req        (req_reg),
            .above_ent  (above_ent),
            .above_drop (above_drop),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .ent_out    (ent[i]),
            .drop_out   (drop[i])
        );
    end

    // Sequence requests and form results
    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        count_next  = count_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        op          = OP_NONE;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                rsp_next.hit       = 1'b0;
                rsp_next.frame_out = '0;
                case (req_reg.req_type)
                    REQ_LOOKUP:
                    begin
                        if (chain[TLB_DEPTH].found)
                        begin
                            rsp_next.hit       = 1'b1;
                            rsp_next.frame_out = chain[TLB_DEPTH].frame;
                            if (hits_reg != '1)
                            begin
                                hits_next = hits_reg + 1'b1;
                            end
                        end
                        else if (misses_reg != '1)
                        begin
                            misses_next = misses_reg + 1'b1;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (chain[TLB_DEPTH].found)
                        begin
                            op = OP_UPDATE;
                        end
                        else if (full)
                        begin
                            op = OP_EVICT_APPEND;
                        end
                        else
                        begin
                            op         = OP_APPEND;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    REQ_INVALIDATE:
                    begin
                        op         = OP_MARK_TAG;
                        done_next  = 1'b0;
                        state_next = ST_SQUEEZE;
                    end
                    REQ_FLUSH_PROC:
                    begin
                        op         = OP_MARK_PROC;
                        done_next  = 1'b0;
                        state_next = ST_SQUEEZE;
                    end
                    REQ_FLUSH_ALL:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        op = OP_NONE;
                    end
                endcase
                rsp_next.hit_count  = hits_next;
                rsp_next.miss_count = misses_next;
            end
            ST_SQUEEZE:
            begin
                // Close the oldest gap, or finish once none remain
                if (chain[TLB_DEPTH].hole)
                begin
                    op         = OP_SQUEEZE;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next          = ST_IDLE;
                    done_next           = 1'b1;
                    rsp_next.hit        = 1'b0;
                    rsp_next.frame_out  = '0;
                    rsp_next.hit_count  = hits_reg;
                    rsp_next.miss_count = misses_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            done_reg   <= done_next;
        end
    end

    // Hold request and result payload
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // Write capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: src/ftlb_cell.sv
// One slot of the translation buffer: holds an entry and a pending-drop mark,
// compares tags and hands data to its older neighbor. Depends on ftlb_pkg.
`timescale 1ns / 1ps

module ftlb_cell
    import ftlb_pkg::*;
#(
    parameter int TLB_DEPTH = 16,
    parameter int IDX       = 0,
    localparam int CNT_W    = $clog2(TLB_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ftlb_op_t         op,
    input  logic [CNT_W-1:0] count,
    input  ftlb_req_t        req,
    input  ftlb_entry_t      above_ent,
    input  logic             above_drop,
    input  ftlb_chain_t      chain_in,
    output ftlb_chain_t      chain_out,
    output ftlb_entry_t      ent_out,
    output logic             drop_out
);

    ftlb_entry_t ent_reg, ent_next;
    logic        drop_reg, drop_next;
    logic        live, pid_match, tag_match, oldest;
    ftlb_entry_t new_ent;

    // Compare tags of a live slot against the request
    assign live      = CNT_W'(IDX) < count;
    assign pid_match = live && (ent_reg.process_id == req.process_id);
    assign tag_match = pid_match && (ent_reg.page_number == req.page_number);
    assign oldest    = tag_match && !chain_in.found;

    // Ripple oldest-match, frame and first-hole toward newer slots
    assign chain_out.found = chain_in.found | tag_match;
    assign chain_out.frame = chain_in.frame | (oldest ? ent_reg.frame_number : '0);
    assign chain_out.hole  = chain_in.hole | (live & drop_reg);

    assign new_ent.process_id   = req.process_id;
    assign new_ent.page_number  = req.page_number;
    assign new_ent.frame_number = req.frame_number;

    // Pick next slot contents from the broadcast command
    always_comb
    begin
        ent_next  = ent_reg;
        drop_next = drop_reg;
        case (op)
            OP_UPDATE:
            begin
                if (oldest)
                begin
                    ent_next.frame_number = req.frame_number;
                end
            end
            OP_APPEND:
            begin
                if (CNT_W'(IDX) == count)
                begin
                    ent_next  = new_ent;
                    drop_next = 1'b0;
                end
            end
            OP_EVICT_APPEND:
            begin
                ent_next  = above_ent;
                drop_next = above_drop;
                if (CNT_W'(IDX + 1) == count)
                begin
                    ent_next  = new_ent;
                    drop_next = 1'b0;
                end
            end
            OP_MARK_TAG:
            begin
                drop_next = tag_match;
            end
            OP_MARK_PROC:
            begin
                drop_next = pid_match;
            end
            OP_SQUEEZE:
            begin
                if (chain_out.hole)
                begin
                    ent_next  = above_ent;
                    drop_next = above_drop;
                end
            end
            default:
            begin
                ent_next  = ent_reg;
                drop_next = drop_reg;
            end
        endcase
    end

    // Hold entry payload
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    // Hold drop mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
        end
        else
        begin
            drop_reg <= drop_next;
        end
    end

    assign ent_out  = ent_reg;
    assign drop_out = drop_reg;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fifo_tlb_with_process_tags_top: a queue-fed driver,
// a shadow translation table that predicts every result beat, and a monitor.
// Depends on ftlb_pkg and the top level under src.

module tb;
    import ftlb_pkg::*;

    localparam int DEPTH           = 16;
    localparam int STALL_LIMIT     = 1000;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int CHUNK           = 40;
    localparam int MAX_GAP         = 13;

    // Request codes the block does not define; they must leave the table alone
    localparam logic [TYPE_W-1:0] REQ_UNUSED_LO  = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_UNUSED_HI  = 3'd7;

    typedef struct {
        ftlb_req_t   beat;
        int unsigned gap;
    } pending_req_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    ftlb_req_t        req       = '0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             busy;
    logic             done;
    ftlb_rsp_t        rsp;

    pending_req_t req_q[$];
    ftlb_rsp_t    rsp_expected_q[$];
    int unsigned  err_count    = 0;
    int unsigned  stall_cycles = 0;

    // Driver staging
    pending_req_t staged;
    logic         staged_valid = 1'b0;
    int unsigned  gap_left     = 0;

    // Shadow copy of the translation table, oldest entry in slot 0
    logic [PID_W-1:0]   sh_pid   [DEPTH];
    logic [PAGE_W-1:0]  sh_page  [DEPTH];
    logic [FRAME_W-1:0] sh_frame [DEPTH];
    int unsigned        sh_count  = 0;
    logic [CNTR_W-1:0]  sh_hits   = '0;
    logic [CNTR_W-1:0]  sh_misses = '0;
    logic [CAP_W-1:0]   sh_cap    = CAP_RESET;

    // Tag pools so that random traffic hits, evicts and removes real entries
    logic [PID_W-1:0]  pid_pool  [4];
    logic [PAGE_W-1:0] page_pool [8];

    fifo_tlb_with_process_tags_top #(
        .TLB_DEPTH(DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Oldest matching slot, or sh_count when the tag is absent
    function automatic int unsigned find_entry(logic [PID_W-1:0] pid,
                                               logic [PAGE_W-1:0] page);
        int unsigned i;
        for (i = 0; i < sh_count; i++)
        begin
            if (sh_pid[i] == pid && sh_page[i] == page)
                return i;
        end
        return sh_count;
    endfunction

    // Drop matching entries and close ranks, keeping the order of survivors
    function automatic void squeeze_out(logic by_page, logic [PID_W-1:0] pid,
                                        logic [PAGE_W-1:0] page);
        int unsigned rd;
        int unsigned wr;
        wr = 0;
        for (rd = 0; rd < sh_count; rd++)
        begin
            if (!(sh_pid[rd] == pid && (!by_page || sh_page[rd] == page)))
            begin
                sh_pid[wr]   = sh_pid[rd];
                sh_page[wr]  = sh_page[rd];
                sh_frame[wr] = sh_frame[rd];
                wr++;
            end
        end
        sh_count = wr;
    endfunction

    // Apply one request to the shadow table and return the result it causes
    function automatic ftlb_rsp_t predict_translation(ftlb_req_t r);
        ftlb_rsp_t   res;
        int unsigned pos;
        int unsigned lim;
        int unsigned i;
        res = '0;
        if (sh_cap == 0)
            lim = 1;
        else if (sh_cap > DEPTH)
            lim = DEPTH;
        else
            lim = sh_cap;
        case (r.req_type)
            REQ_LOOKUP:
            begin
                pos = find_entry(r.process_id, r.page_number);
                if (pos < sh_count)
                begin
                    res.hit       = 1'b1;
                    res.frame_out = sh_frame[pos];
                    if (sh_hits != '1)
                        sh_hits++;
                end
                else if (sh_misses != '1)
                begin
                    sh_misses++;
                end
            end
            REQ_INSERT:
            begin
                pos = find_entry(r.process_id, r.page_number);
                if (pos < sh_count)
                begin
                    sh_frame[pos] = r.frame_number;
                end
                else
                begin
                    // Evict only the single oldest entry, even if capacity dropped further
                    if (sh_count >= lim && sh_count != 0)
                    begin
                        for (i = 1; i < sh_count; i++)
                        begin
                            sh_pid[i-1]   = sh_pid[i];
                            sh_page[i-1]  = sh_page[i];
                            sh_frame[i-1] = sh_frame[i];
                        end
                        sh_count--;
                    end
                    if (sh_count < DEPTH)
                    begin
                        sh_pid[sh_count]   = r.process_id;
                        sh_page[sh_count]  = r.page_number;
                        sh_frame[sh_count] = r.frame_number;
                        sh_count++;
                    end
                end
            end
            REQ_INVALIDATE: squeeze_out(1'b1, r.process_id, r.page_number);
            REQ_FLUSH_PROC: squeeze_out(1'b0, r.process_id, '0);
            REQ_FLUSH_ALL:  sh_count = 0;
            default:        ;
        endcase
        res.hit_count  = sh_hits;
        res.miss_count = sh_misses;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        err_count++;
    endtask

    task automatic queue_req(logic [TYPE_W-1:0] kind, logic [PID_W-1:0] pid,
                             logic [PAGE_W-1:0] page, logic [FRAME_W-1:0] frame);
        pending_req_t p;
        p.beat.req_type     = kind;
        p.beat.process_id   = pid;
        p.beat.page_number  = page;
        p.beat.frame_number = frame;
        p.gap               = $urandom_range(0, MAX_GAP);
        req_q               = {req_q, p};
    endtask

    // Wait on the falling edge until no beat is pending or outstanding
    task automatic wait_drain();
        do
            @(negedge clk);
        while (req_q.size() != 0 || staged_valid || start || busy ||
               rsp_expected_q.size() != 0);
    endtask

    // Driver: predict on each accepted beat, hold while busy, then idle or advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            req          <= '0;
            staged_valid = 1'b0;
            gap_left     = 0;
            sh_count     = 0;
            sh_hits      = '0;
            sh_misses    = '0;
            sh_cap       = CAP_RESET;
        end
        else
        begin
            if (cfg_we)
                sh_cap = cfg_wdata;
            if (start && !busy)
                rsp_expected_q = {rsp_expected_q, predict_translation(req)};
            if (!(start && busy))
            begin
                if (!staged_valid && req_q.size() != 0)
                begin
                    staged       = req_q[0];
                    req_q.delete(0);
                    staged_valid = 1'b1;
                    gap_left     = staged.gap;
                end
                if (staged_valid && gap_left == 0)
                begin
                    req          <= staged.beat;
                    start        <= 1'b1;
                    staged_valid = 1'b0;
                end
                else
                begin
                    start <= 1'b0;
                    if (staged_valid)
                        gap_left--;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        ftlb_rsp_t want;
        if (rst_n && done)
        begin
            if (rsp_expected_q.size() == 0)
            begin
                report_mismatch("result beat with nothing expected",
                                64'(rsp.hit_count), '0);
            end
            else
            begin
                want = rsp_expected_q[0];
                rsp_expected_q.delete(0);
                if (rsp.hit !== want.hit)
                    report_mismatch("hit", 64'(rsp.hit), 64'(want.hit));
                if (rsp.frame_out !== want.frame_out)
                    report_mismatch("frame_out", 64'(rsp.frame_out), 64'(want.frame_out));
                if (rsp.hit_count !== want.hit_count)
                    report_mismatch("hit_count", 64'(rsp.hit_count), 64'(want.hit_count));
                if (rsp.miss_count !== want.miss_count)
                    report_mismatch("miss_count", 64'(rsp.miss_count),
                                    64'(want.miss_count));
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles == STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Stimulus: directed requests, then random phases at several capacities
    initial
    begin
        logic [CAP_W-1:0] cap_plan [NUM_PHASES];
        pending_req_t     p;
        int unsigned      phase;
        int unsigned      n;
        int unsigned      i;
        int unsigned      pick;
        logic             quiet;

        cap_plan = '{5'd4, 5'd1, 5'd0, 5'd31, 5'd16, 5'd7, 5'd2, 5'd12, 5'd15, 5'd3};
        cap_plan[7] = CAP_W'($urandom_range(0, 31));
        quiet = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table, extreme tags, update in place
        queue_req(REQ_LOOKUP, '0, '0, '1);
        queue_req(REQ_INSERT, '1, '1, '1);
        queue_req(REQ_INSERT, '0, '0, '0);
        queue_req(REQ_LOOKUP, '1, '1, '0);
        queue_req(REQ_LOOKUP, '0, '0, '1);
        queue_req(REQ_INSERT, '1, '1, 20'h12345);
        queue_req(REQ_LOOKUP, '1, '1, '0);
        // Same page under different processes, then remove one tag
        queue_req(REQ_INSERT, 16'd1, 52'd5, 20'hAAAAA);
        queue_req(REQ_INSERT, 16'd1, 52'd6, 20'h55555);
        queue_req(REQ_INSERT, 16'd2, 52'd5, 20'h0F0F0);
        queue_req(REQ_INVALIDATE, 16'd1, 52'd5, '1);
        queue_req(REQ_LOOKUP, 16'd1, 52'd5, '0);
        queue_req(REQ_LOOKUP, 16'd1, 52'd6, '0);
        // Flush one process, the rest survive in order
        queue_req(REQ_FLUSH_PROC, 16'd1, '1, '0);
        queue_req(REQ_LOOKUP, 16'd1, 52'd6, '0);
        queue_req(REQ_LOOKUP, 16'd2, 52'd5, '0);
        queue_req(REQ_INVALIDATE, 16'd9, 52'd9, '0);
        // Undefined request codes carry unchanged counters
        queue_req(REQ_UNUSED_LO, '1, '1, '1);
        queue_req(REQ_UNUSED_MID, 16'd2, 52'd5, '1);
        queue_req(REQ_UNUSED_HI, '1, '0, '1);
        queue_req(REQ_LOOKUP, 16'd2, 52'd5, '0);
        queue_req(REQ_FLUSH_ALL, '1, '1, '1);
        queue_req(REQ_LOOKUP, '0, '0, '0);
        queue_req(REQ_LOOKUP, '1, '1, '0);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drain();

            // Write the capacity while the table is idle; entries are kept
            repeat (3) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= cap_plan[phase];
            @(posedge clk);
            cfg_we    <= 1'b0;
            @(negedge clk);

            for (i = 0; i < 4; i++)
                pid_pool[i] = PID_W'($urandom);
            for (i = 0; i < 8; i++)
                page_pool[i] = PAGE_W'({$urandom, $urandom});

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % CHUNK == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                pick = $urandom_range(0, 99);
                p.beat.process_id   = pid_pool[$urandom_range(0, 3)];
                p.beat.page_number  = page_pool[$urandom_range(0, 7)];
                p.beat.frame_number = FRAME_W'($urandom);
                if (pick < 40)
                    p.beat.req_type = REQ_LOOKUP;
                else if (pick < 75)
                    p.beat.req_type = REQ_INSERT;
                else if (pick < 85)
                    p.beat.req_type = REQ_INVALIDATE;
                else if (pick < 90)
                    p.beat.req_type = REQ_FLUSH_PROC;
                else if (pick < 92)
                    p.beat.req_type = REQ_FLUSH_ALL;
                else if (pick < 96)
                    p.beat.req_type = TYPE_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                else
                begin
                    // Noise: a tag outside the pools
                    p.beat.req_type    = pick[0] ? REQ_LOOKUP : REQ_INVALIDATE;
                    p.beat.process_id  = PID_W'($urandom);
                    p.beat.page_number = PAGE_W'({$urandom, $urandom});
                end
                p.gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
                req_q = {req_q, p};
            end
        end

        wait_drain();
        repeat (30) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
